### rtl/core/primary_ray_generation_assert.svh
// Assertion macros for the primary ray generation block.
// No dependencies; included by the checker file.
`ifndef PRIMARY_RAY_GENERATION_ASSERT_SVH
`define PRIMARY_RAY_GENERATION_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PRG_ASSERT_IMP(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define PRG_ASSERT_NXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);
`endif

### rtl/core/prg_pkg.sv
// Package for primary ray generation: payload structs, constants, helpers.
// No dependencies.
package prg_pkg;
   localparam int COORD_FRAC_BITS_DEF = 8;
   localparam int DIR_FRAC_BITS_DEF   = 14;
   localparam int COMP_W   = 20;
   localparam int DIR_W    = 16;
   localparam int DIM_W    = 13;
   localparam int PIX_W    = 16;
   localparam int VEC_W    = 60;
   localparam int NDC_W    = 20;   // signed ndc, 16 fraction bits
   localparam int DEN_W    = 17;   // 16*dim
   localparam int NUM_W    = 34;   // 2*pix*2^16 + 8*dim
   localparam int CSR_AW   = 6;
   localparam int CSR_DW   = 64;
   localparam int QUO_W    = 35;   // unused; the direction divide quotient is DQW, 36 bits by default
   localparam int MAG_W    = 21;
   localparam int SUM_W    = 44;
   localparam int LEN_W    = 22;

   typedef enum logic [2:0] {
      REG_EYE   = 3'd0,
      REG_REF   = 3'd1,
      REG_HSPAN = 3'd2,
      REG_VSPAN = 3'd3,
      REG_WIDTH = 3'd4,
      REG_HEIGHT = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_x;
      logic [PIX_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] origin_x;
      logic signed [COMP_W-1:0] origin_y;
      logic signed [COMP_W-1:0] origin_z;
      logic signed [DIR_W-1:0]  dir_x;
      logic signed [DIR_W-1:0]  dir_y;
      logic signed [DIR_W-1:0]  dir_z;
      logic                     degenerate;
   } rsp_type;

   typedef struct packed {
      logic [VEC_W-1:0] eye_pos;
      logic [VEC_W-1:0] ref_pos;
      logic [VEC_W-1:0] horiz_span;
      logic [VEC_W-1:0] vert_span;
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
   } cfg_type;

   function automatic logic signed [COMP_W-1:0] comp_of(input logic [VEC_W-1:0] v,
                                                         input int unsigned i);
      comp_of = v[i*COMP_W +: COMP_W];
   endfunction
endpackage

### rtl/core/prg_divu.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on prg_pkg. Carries a side payload alongside.
module prg_divu #(
   parameter int NW = 34,
   parameter int DW = 17,
   parameter int QW = 34,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);
   import prg_pkg::*;
   localparam int RW = DW + 1;
   logic [QW:0]           vld_ff;
   logic [RW-1:0]         rem_ff  [QW+1];
   logic [NW-1:0]         num_ff  [QW+1];
   logic [DW-1:0]         den_ff  [QW+1];
   logic [QW-1:0]         quo_ff  [QW+1];
   logic [SW-1:0]         side_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[QW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= '0;
         num_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         quo_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [RW:0]   trial;
      logic [RW:0]   diff;
      logic          nbit;
      always_comb begin
         nbit  = (QW-1-s < NW) ? num_ff[s][(QW-1-s < NW) ? QW-1-s : 0] : 1'b0;
         trial = {rem_ff[s], nbit};
         diff  = trial - {2'b00, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!diff[RW]) begin
               rem_ff[s+1] <= diff[RW-1:0];
            end else begin
               rem_ff[s+1] <= trial[RW-1:0];
            end
            quo_ff[s+1]  <= {quo_ff[s][QW-2:0], ~diff[RW]};
            num_ff[s+1]  <= num_ff[s];
            den_ff[s+1]  <= den_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_side  = side_ff[QW];
endmodule

### rtl/core/prg_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on prg_pkg. Carries a side payload alongside.
module prg_isqrt #(
   parameter int XW = 44,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [XW-1:0] in_x,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [XW/2-1:0] out_root,
   output logic [SW-1:0] out_side
);
   import prg_pkg::*;
   localparam int RW = XW / 2;
   localparam int RMW = RW + 2;
   logic [RW:0]    vld_ff;
   logic [XW-1:0]  x_ff    [RW+1];
   logic [RMW-1:0] rem_ff  [RW+1];
   logic [RW-1:0]  root_ff [RW+1];
   logic [SW-1:0]  side_ff [RW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[RW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= in_x;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   // digit-by-digit: rem = rem*4 + next pair; trial = 4*root + 1
   for (genvar s = 0; s < RW; s++) begin : g_stage
      logic [RMW:0] rem_sh;
      logic [RMW:0] trial;
      logic [RMW:0] diff;
      always_comb begin
         rem_sh = {rem_ff[s][RMW-2:0], x_ff[s][XW-1-2*s -: 2]};
         trial  = {1'b0, root_ff[s], 2'b01};
         diff   = rem_sh - trial;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!diff[RMW]) begin
               rem_ff[s+1] <= diff[RMW-1:0];
            end else begin
               rem_ff[s+1] <= rem_sh[RMW-1:0];
            end
            root_ff[s+1] <= {root_ff[s][RW-2:0], ~diff[RMW]};
            x_ff[s+1]    <= x_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_side  = side_ff[RW];
endmodule

### rtl/core/primary_ray_generation.sv
// Top level of the pinhole camera primary ray generator.
// Depends on prg_pkg, prg_divu and prg_isqrt.
//
// One pixel request (unsigned 12.4 x and y) enters per cycle and yields one
// ray: origin is the eye, direction is the Q1.14 unit vector from the eye to
// ref + ndcX*H + ndcY*V. Throughput is one request per clock while rsp_stall
// does not hold the pipe. Each request passes three bit-serial pipelines in
// series: the NDC divide (input register plus 34 quotient stages), the
// integer square root and the direction divide, with five multiply/normalize
// stages after the NDC divide, and finally the output register.
// The whole pipe advances when the output register is empty or being taken;
// rsp_stall freezes every stage, so nothing is lost or repeated. Camera
// registers sit on an APB-style port (64-bit data, address 8*index) and must
// only be written while the pipe is empty. A zero-length view direction
// returns zero direction with degenerate set.
module primary_ray_generation
   import prg_pkg::*;
#(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   parameter int DIR_FRAC_BITS   = DIR_FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  prg_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output prg_pkg::rsp_type         rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [prg_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [prg_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [prg_pkg::CSR_DW-1:0] csr_prdata,
   output logic                     csr_pready
);
   import prg_pkg::*;

   localparam int SHW = 5;
   localparam int DQW = DIR_FRAC_BITS + MAG_W + 1;
   localparam int DNW = MAG_W + DIR_FRAC_BITS + 1;
   localparam int VEC3 = 3;
   localparam int NDCW = 32;   // signed ndc, 16 fraction bits
   localparam int PRW  = 52;   // ndc times one span component
   localparam int TW   = PRW + 1;

   // ---------------- configuration registers ----------------
   cfg_type cfg_ff;
   logic    wr_en;
   reg_index_type widx;
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign widx  = reg_index_type'(csr_paddr[CSR_AW-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.eye_pos      <= '0;
         cfg_ff.ref_pos      <= '0;
         cfg_ff.horiz_span   <= '0;
         cfg_ff.vert_span    <= '0;
         cfg_ff.image_width  <= DIM_W'(400);
         cfg_ff.image_height <= DIM_W'(400);
      end else if (wr_en) begin
         case (widx)
            REG_EYE:    cfg_ff.eye_pos      <= csr_pwdata[VEC_W-1:0];
            REG_REF:    cfg_ff.ref_pos      <= csr_pwdata[VEC_W-1:0];
            REG_HSPAN:  cfg_ff.horiz_span   <= csr_pwdata[VEC_W-1:0];
            REG_VSPAN:  cfg_ff.vert_span    <= csr_pwdata[VEC_W-1:0];
            REG_WIDTH:  cfg_ff.image_width  <= csr_pwdata[DIM_W-1:0];
            REG_HEIGHT: cfg_ff.image_height <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_index_type'(csr_paddr[CSR_AW-1:3]))
         REG_EYE:    csr_prdata = CSR_DW'(cfg_ff.eye_pos);
         REG_REF:    csr_prdata = CSR_DW'(cfg_ff.ref_pos);
         REG_HSPAN:  csr_prdata = CSR_DW'(cfg_ff.horiz_span);
         REG_VSPAN:  csr_prdata = CSR_DW'(cfg_ff.vert_span);
         REG_WIDTH:  csr_prdata = CSR_DW'(cfg_ff.image_width);
         REG_HEIGHT: csr_prdata = CSR_DW'(cfg_ff.image_height);
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- global advance ----------------
   logic adv;
   assign adv       = ~rsp_valid | ~rsp_stall;
   assign req_stall = ~adv;

   // ---------------- NDC dividers ----------------
   logic [DIM_W-1:0] wdim, hdim;
   logic [DEN_W-1:0] wden, hden;
   logic [NUM_W-1:0] xnum, ynum;
   assign wdim = (cfg_ff.image_width  == '0) ? DIM_W'(1) : cfg_ff.image_width;
   assign hdim = (cfg_ff.image_height == '0) ? DIM_W'(1) : cfg_ff.image_height;
   assign wden = {wdim, 4'b0000};
   assign hden = {hdim, 4'b0000};
   assign xnum = {1'b0, req_data.pixel_x, 17'd0} + {18'd0, wdim, 3'b000};
   assign ynum = {1'b0, req_data.pixel_y, 17'd0} + {18'd0, hdim, 3'b000};

   logic            dx_valid, dy_valid;
   logic [NUM_W-1:0] qx, qy;
   logic [0:0]      sx_unused, sy_unused;

   prg_divu #(.NW(NUM_W), .DW(DEN_W), .QW(NUM_W), .SW(1)) u_divx (
      .clock, .reset, .adv,
      .in_valid(req_valid), .in_num(xnum), .in_den(wden), .in_side(1'b0),
      .out_valid(dx_valid), .out_quo(qx), .out_side(sx_unused));
   prg_divu #(.NW(NUM_W), .DW(DEN_W), .QW(NUM_W), .SW(1)) u_divy (
      .clock, .reset, .adv,
      .in_valid(req_valid), .in_num(ynum), .in_den(hden), .in_side(1'b0),
      .out_valid(dy_valid), .out_quo(qy), .out_side(sy_unused));

   // quotient stays below 2^29 even for a one-pixel image
   logic signed [NDCW-1:0] ndcx, ndcy;
   assign ndcx = $signed({2'b00, qx[29:0]}) - 32'sd65536;
   assign ndcy = 32'sd65536 - $signed({2'b00, qy[29:0]});

   // ---------------- stage M: products ----------------
   logic              m_valid_ff;
   logic signed [PRW-1:0] th_ff [VEC3];
   logic signed [PRW-1:0] tv_ff [VEC3];
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= dx_valid & dy_valid;
      end
   end
   for (genvar i = 0; i < VEC3; i++) begin : g_mul
      always_ff @(posedge clock) begin
         if (adv) begin
            th_ff[i] <= PRW'(ndcx * comp_of(cfg_ff.horiz_span, i));
            tv_ff[i] <= PRW'(ndcy * comp_of(cfg_ff.vert_span, i));
         end
      end
   end

   // ---------------- stage P: target point, difference ----------------
   logic              p_valid_ff;
   logic signed [21:0] d_ff [VEC3];
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= m_valid_ff;
      end
   end
   for (genvar i = 0; i < VEC3; i++) begin : g_pt
      logic signed [TW-1:0] t;
      logic signed [45:0] p;
      logic signed [COMP_W-1:0] ps;
      always_comb begin
         t = TW'(th_ff[i]) + TW'(tv_ff[i]) + TW'(32768);
         p = 46'(comp_of(cfg_ff.ref_pos, i)) + 46'(t >>> 16);
         if (p > 46'sd524287) begin
            ps = 20'sh7FFFF;
         end else if (p < -46'sd524288) begin
            ps = 20'sh80000;
         end else begin
            ps = p[COMP_W-1:0];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            d_ff[i] <= 22'(ps) - 22'(comp_of(cfg_ff.eye_pos, i));
         end
      end
   end

   // ---------------- stage A: magnitudes, signs, OR of magnitudes ----------------
   logic              a_valid_ff;
   logic [MAG_W-1:0]  mag_ff [VEC3];
   logic [VEC3-1:0]   sgn_ff;
   logic [MAG_W-1:0]  max_ff;
   logic [MAG_W-1:0]  mag_c [VEC3];
   always_comb begin
      for (int i = 0; i < VEC3; i++) begin
         mag_c[i] = d_ff[i][21] ? MAG_W'(-d_ff[i]) : MAG_W'(d_ff[i]);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= p_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < VEC3; i++) begin
            mag_ff[i] <= mag_c[i];
            sgn_ff[i] <= d_ff[i][21];
         end
         max_ff <= (mag_c[0] | mag_c[1] | mag_c[2]);
      end
   end

   // ---------------- stage N: normalize shift ----------------
   // leading-one position of OR of magnitudes equals that of the max
   logic [SHW-1:0] sh_c;
   always_comb begin
      sh_c = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (max_ff[b]) begin
            sh_c = SHW'(MAG_W - 1 - b);
         end
      end
   end
   logic              n_valid_ff;
   logic [MAG_W-1:0]  nm_ff [VEC3];
   logic [VEC3-1:0]   nsg_ff;
   logic              ndeg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else if (adv) begin
         n_valid_ff <= a_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < VEC3; i++) begin
            nm_ff[i] <= mag_ff[i] << sh_c;
         end
         nsg_ff  <= sgn_ff;
         ndeg_ff <= (max_ff == '0);
      end
   end

   // ---------------- stage S: squares ----------------
   logic              s_valid_ff;
   logic [41:0]       sq_ff [VEC3];
   logic [MAG_W-1:0]  sm_ff [VEC3];
   logic [VEC3-1:0]   ssg_ff;
   logic              sdeg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (adv) begin
         s_valid_ff <= n_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < VEC3; i++) begin
            sq_ff[i] <= nm_ff[i] * nm_ff[i];
            sm_ff[i] <= nm_ff[i];
         end
         ssg_ff  <= nsg_ff;
         sdeg_ff <= ndeg_ff;
      end
   end

   logic [SUM_W-1:0] sum_c;
   assign sum_c = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);

   // ---------------- square root ----------------
   localparam int SIDE_W = 3 * MAG_W + 4;
   logic [SIDE_W-1:0] r_side_in, r_side_out;
   logic              r_valid;
   logic [LEN_W-1:0]  len;
   assign r_side_in = {sdeg_ff, ssg_ff, sm_ff[2], sm_ff[1], sm_ff[0]};
   prg_isqrt #(.XW(SUM_W), .SW(SIDE_W)) u_sqrt (
      .clock, .reset, .adv,
      .in_valid(s_valid_ff), .in_x(sum_c), .in_side(r_side_in),
      .out_valid(r_valid), .out_root(len), .out_side(r_side_out));

   logic [MAG_W-1:0] rm [VEC3];
   logic [VEC3-1:0]  rsg;
   logic             rdeg;
   logic [LEN_W-1:0] lden;
   assign rm[0] = r_side_out[MAG_W-1:0];
   assign rm[1] = r_side_out[2*MAG_W-1:MAG_W];
   assign rm[2] = r_side_out[3*MAG_W-1:2*MAG_W];
   assign rsg   = r_side_out[3*MAG_W+2:3*MAG_W];
   assign rdeg  = r_side_out[3*MAG_W+3];
   assign lden  = rdeg ? LEN_W'(1) : len;

   // ---------------- direction dividers ----------------
   logic [VEC3-1:0] q_valid;
   logic [DQW-1:0]  dq [VEC3];
   logic [3:0]      qside [VEC3];
   for (genvar i = 0; i < VEC3; i++) begin : g_ddiv
      logic [DNW-1:0] num;
      assign num = (DNW'(rm[i]) << DIR_FRAC_BITS) + DNW'(lden >> 1);
      prg_divu #(.NW(DNW), .DW(LEN_W), .QW(DQW), .SW(4)) u_div (
         .clock, .reset, .adv,
         .in_valid(r_valid), .in_num(num), .in_den(lden),
         .in_side({rdeg, rsg}),
         .out_valid(q_valid[i]), .out_quo(dq[i]), .out_side(qside[i]));
   end

   // ---------------- output register ----------------
   logic [DIR_W-1:0] dir_c [VEC3];
   always_comb begin
      for (int i = 0; i < VEC3; i++) begin
         if (qside[0][3]) begin
            dir_c[i] = '0;
         end else if (qside[i][i]) begin
            dir_c[i] = DIR_W'(-dq[i]);
         end else begin
            dir_c[i] = DIR_W'(dq[i]);
         end
      end
   end

   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= q_valid[0] & q_valid[1] & q_valid[2];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.origin_x   <= comp_of(cfg_ff.eye_pos, 0);
         rsp_ff.origin_y   <= comp_of(cfg_ff.eye_pos, 1);
         rsp_ff.origin_z   <= comp_of(cfg_ff.eye_pos, 2);
         rsp_ff.dir_x      <= dir_c[0];
         rsp_ff.dir_y      <= dir_c[1];
         rsp_ff.dir_z      <= dir_c[2];
         rsp_ff.degenerate <= qside[0][3];
      end
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sink for bits that carry no information
   logic unused_ok;
   assign unused_ok = (COORD_FRAC_BITS > 0) &
                      ~|{sx_unused, sy_unused, qx[NUM_W-1:30], qy[NUM_W-1:30],
                         csr_paddr[2:0]};
endmodule

### rtl/core/prg_checker.sv
// Port-level checker for primary_ray_generation, bound to the top level.
// Depends on prg_pkg and primary_ray_generation_assert.svh.
`include "primary_ray_generation_assert.svh"
module prg_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input prg_pkg::rsp_type rsp_data,
   input logic             csr_pready
);
   import prg_pkg::*;
   `PRG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "held response changed")
   `PRG_ASSERT_IMP(a_stall_src, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled without output back-pressure")
   `PRG_ASSERT_IMP(a_deg_zero, clock, reset, rsp_valid && rsp_data.degenerate, rsp_data.dir_x == 0 && rsp_data.dir_y == 0 && rsp_data.dir_z == 0, "degenerate ray with nonzero direction")
   `PRG_ASSERT_IMP(a_pready, clock, reset, 1'b1, csr_pready, "pready low")
endmodule

bind primary_ray_generation prg_checker u_prg_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_data, .csr_pready);
